>>> sv/circular_deque_defines.svh
// assertion macros for the circular deque block
// used by circular_deque.sv, no other dependencies
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular deque check failed");
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular deque check failed");
`else
`define CDQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/cdq_pkg.sv
// shared types and constants for the circular deque block
// no dependencies
`default_nettype none

package cdq_pkg;

    localparam int CNT_W   = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_AW  = 1;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FORBIDDEN = 2'd3
    } status_t;

    localparam logic [CFG_AW-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_AW-1:0] REG_MODE     = 1'b1;

    localparam logic [1:0] MODE_NO_FRONT_PUSH = 2'd1;
    localparam logic [1:0] MODE_NO_REAR_POP   = 2'd2;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

`default_nettype wire

>>> sv/cdq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/circular_deque.sv
// circular deque: an accepted beat gives its result beat in the next cycle
// throughput one operation per cycle while m_tready stays high, set by one slot access per beat on the ram
// s_tready follows m_tready through a single result register
// reset clears head, count, valid and the config registers (capacity 16, mode 0)
// slot contents are not cleared; a pop only reaches slots already written
// depends on cdq_pkg, cdq_ram and circular_deque_defines.svh
`default_nettype none
`include "circular_deque_defines.svh"

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // value[31:0]
    input  wire logic [1:0]        s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [39:0]       m_tdata,   // removed_value[31:0], count[36:32], zero[39:37]
    output logic      [1:0]        m_tuser    // status[1:0]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH < 31) ? DEPTH : 31);

    logic [CNT_W-1:0] cap_reg;
    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] held_reg;
    logic             m_valid_reg;
    status_t          status_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop_ok_reg;

    logic [CNT_W-1:0] cap_live;
    logic             s_fire;
    kind_t            kind;
    status_t          status_next;
    logic [CNT_W-1:0] head_next;
    logic [CNT_W-1:0] held_next;
    logic             ram_we;
    logic             ram_re;
    logic [CNT_W-1:0] pos;
    logic [CNT_W:0]   sum_rear;
    logic [CNT_W:0]   sum_rear_m1;
    logic [WIDTH-1:0] ram_rdata;

    assign cap_live = (cap_reg == '0) ? CNT_W'(1) :
                      ((cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);

    assign sum_rear    = {1'b0, head_reg} + {1'b0, held_reg};
    assign sum_rear_m1 = sum_rear - (CNT_W+1)'(1);

    always_comb begin
        status_next = ST_OK;
        head_next   = head_reg;
        held_next   = held_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        pos         = head_reg;
        if ((kind == KIND_PUSH_FRONT && mode_reg == MODE_NO_FRONT_PUSH) ||
            (kind == KIND_POP_REAR && mode_reg == MODE_NO_REAR_POP)) begin
            status_next = ST_FORBIDDEN;
        end else begin
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                    if (held_reg >= cap_live) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        held_next = held_reg + CNT_W'(1);
                        if (kind == KIND_PUSH_FRONT) begin
                            head_next = (head_reg == '0) ? cap_live - CNT_W'(1)
                                                         : head_reg - CNT_W'(1);
                            pos       = head_next;
                        end else if (sum_rear >= {1'b0, cap_live}) begin
                            pos = CNT_W'(sum_rear - {1'b0, cap_live});
                        end else begin
                            pos = CNT_W'(sum_rear);
                        end
                    end
                end
                default: begin
                    if (held_reg == '0) begin
                        status_next = ST_UNDERFLOW;
                    end else begin
                        ram_re    = 1'b1;
                        held_next = held_reg - CNT_W'(1);
                        if (kind == KIND_POP_FRONT) begin
                            pos       = head_reg;
                            head_next = (head_reg + CNT_W'(1) == cap_live) ? '0
                                                                          : head_reg + CNT_W'(1);
                        end else if (sum_rear_m1 >= {1'b0, cap_live}) begin
                            pos = CNT_W'(sum_rear_m1 - {1'b0, cap_live});
                        end else begin
                            pos = CNT_W'(sum_rear_m1);
                        end
                    end
                end
            endcase
        end
    end

    cdq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (s_fire && ram_we),
        .waddr (AW'(pos)),
        .wdata (WIDTH'(s_tdata)),
        .re    (s_fire && ram_re),
        .raddr (AW'(pos)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAPACITY_RESET;
            mode_reg    <= '0;
            head_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == REG_CAPACITY) begin
                cap_reg  <= cfg_wdata;
                head_reg <= '0;
                held_reg <= '0;
            end else if (s_fire) begin
                head_reg <= head_next;
                held_reg <= held_next;
            end
            if (cfg_we && cfg_addr == REG_MODE) begin
                mode_reg <= cfg_wdata[1:0];
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            count_reg  <= held_next;
            pop_ok_reg <= ram_re;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, count_reg, pop_ok_reg ? VALUE_W'(ram_rdata) : VALUE_W'(0)};

    `CDQ_ASSERT_SAME(a_count_le_cap, aclk, aresetn, 1'b1, held_reg <= cap_live)
    `CDQ_ASSERT_SAME(a_head_lt_cap, aclk, aresetn, 1'b1, head_reg < cap_live)
    `CDQ_ASSERT_NEXT(a_fire_gives_beat, aclk, aresetn, s_fire, m_valid_reg)
    `CDQ_ASSERT_SAME(a_fail_no_value, aclk, aresetn, m_valid_reg && status_reg != ST_OK, m_tdata[31:0] == '0)
    `CDQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, s_fire && ram_we && !cfg_we, held_reg == $past(held_reg) + CNT_W'(1))

endmodule

`default_nettype wire

>>> verif/circular_deque_tb.sv
`timescale 1ns / 1ps
// testbench for circular_deque: directed and random push/pop beats checked against a
// local deque model with random stalls on both stream sides; depends on cdq_pkg
module circular_deque_tb;
    import cdq_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        status_t     status;
        logic [31:0] removed;
        logic [4:0]  count;
    } deque_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;
    logic [1:0]        m_tuser;

    // local copy of the deque and its registers
    logic [31:0]  mirror_slots [SLOT_COUNT];
    int unsigned  mirror_head     = 0;
    int unsigned  mirror_count    = 0;
    logic [4:0]   mirror_capacity = CAPACITY_RESET;
    logic [1:0]   mirror_mode     = 2'd0;

    deque_result_t awaited_results[$];
    int            mismatch_count = 0;
    bit            tx_idle_on     = 1'b0;
    bit            rx_idle_on     = 1'b0;
    int            stall_left     = 0;
    int            quiet_cycles   = 0;

    circular_deque i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic deque_result_t apply_deque_op(input kind_t op, input logic [31:0] value);
        deque_result_t res;
        int unsigned   cap;
        int unsigned   pos;
        cap = mirror_capacity;
        if (cap == 0) cap = 1;
        if (cap > SLOT_COUNT) cap = SLOT_COUNT;
        res.status  = ST_OK;
        res.removed = '0;
        if ((op == KIND_PUSH_FRONT && mirror_mode == MODE_NO_FRONT_PUSH) ||
            (op == KIND_POP_REAR && mirror_mode == MODE_NO_REAR_POP)) begin
            res.status = ST_FORBIDDEN;
        end else if (op == KIND_PUSH_FRONT || op == KIND_PUSH_REAR) begin
            if (mirror_count >= cap) begin
                res.status = ST_OVERFLOW;
            end else if (op == KIND_PUSH_FRONT) begin
                mirror_head = (mirror_head + cap - 1) % cap;
                mirror_slots[mirror_head] = value;
                mirror_count++;
            end else begin
                pos = (mirror_head + mirror_count) % cap;
                mirror_slots[pos] = value;
                mirror_count++;
            end
        end else if (mirror_count == 0) begin
            res.status = ST_UNDERFLOW;
        end else if (op == KIND_POP_FRONT) begin
            res.removed = mirror_slots[mirror_head];
            mirror_head = (mirror_head + 1) % cap;
            mirror_count--;
        end else begin
            pos = (mirror_head + mirror_count - 1) % cap;
            res.removed = mirror_slots[pos];
            mirror_count--;
        end
        res.count = 5'(mirror_count);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch on %s: got %h expected %h at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // one operation beat, held until accepted
    task automatic send_op(input kind_t op, input logic [31:0] value);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        awaited_results.push_back(apply_deque_op(op, value));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (addr == REG_CAPACITY) begin
            mirror_capacity = data;
            mirror_head     = 0;
            mirror_count    = 0;
        end else begin
            mirror_mode = data[1:0];
        end
    endtask

    task automatic send_random_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            send_op(kind_t'($urandom_range(0, 1)), $urandom);
        else
            send_op(kind_t'($urandom_range(2, 3)), $urandom);
    endtask

    task automatic test_basic_ops();
        send_op(KIND_POP_FRONT, $urandom);
        send_op(KIND_POP_REAR, $urandom);
        send_op(KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_op(KIND_PUSH_REAR, 32'h8000_0000);
        send_op(KIND_PUSH_FRONT, 32'h0000_0000);
        send_op(KIND_PUSH_REAR, 32'hffff_ffff);
        send_op(KIND_POP_REAR, $urandom);
        send_op(KIND_POP_FRONT, $urandom);
        send_op(KIND_POP_REAR, $urandom);
        send_op(KIND_POP_FRONT, $urandom);
    endtask

    task automatic test_capacity_limits();
        // capacity write drops held elements
        send_op(KIND_PUSH_REAR, 32'h1234_5678);
        write_reg(REG_CAPACITY, 5'd16);
        send_op(KIND_POP_FRONT, $urandom);
        // zero acts as one
        write_reg(REG_CAPACITY, 5'd0);
        send_op(KIND_PUSH_REAR, 32'h5555_aaaa);
        send_op(KIND_PUSH_FRONT, 32'haaaa_5555);
        // above the store depth acts as the depth
        write_reg(REG_CAPACITY, 5'd17);
        send_op(KIND_PUSH_FRONT, 32'haaaa_5555);
        send_op(KIND_POP_REAR, $urandom);
    endtask

    task automatic test_restriction_modes();
        write_reg(REG_CAPACITY, 5'd1);
        send_op(KIND_PUSH_REAR, 32'hdead_beef);
        // mode check wins over full and empty
        write_reg(REG_MODE, 5'(MODE_NO_FRONT_PUSH));
        send_op(KIND_PUSH_FRONT, $urandom);
        send_op(KIND_PUSH_REAR, $urandom);
        write_reg(REG_MODE, 5'(MODE_NO_REAR_POP));
        send_op(KIND_POP_REAR, $urandom);
        send_op(KIND_POP_FRONT, $urandom);
        send_op(KIND_POP_REAR, $urandom);
        // unused mode is unrestricted
        write_reg(REG_MODE, 5'd3);
        send_op(KIND_PUSH_FRONT, 32'h0f0f_f0f0);
        send_op(KIND_POP_REAR, $urandom);
        write_reg(REG_MODE, 5'd0);
    endtask

    task automatic test_random_phases();
        int            push_pct;
        logic [4:0]    cap;
        for (int phase = 0; phase < 24; phase++) begin
            case (phase % 6)
                0:       cap = 5'd1;
                1:       cap = 5'd2;
                2:       cap = 5'd16;
                3:       cap = 5'd0;
                4:       cap = 5'd31;
                default: cap = 5'($urandom_range(0, 31));
            endcase
            write_reg(REG_CAPACITY, cap);
            write_reg(REG_MODE, (phase < 4) ? 5'(phase) : 5'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0:       push_pct = 20;
                1:       push_pct = 50;
                2:       push_pct = 80;
                default: push_pct = $urandom_range(10, 90);
            endcase
            tx_idle_on = (phase < 21) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase < 21) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 60; n++) begin
                if (phase == 7 && n == 30)
                    drain_results();
                // swing between filling and draining so full and empty both show up
                if (n == 30)
                    push_pct = 100 - push_pct;
                send_random_op(push_pct);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_capacity_limits();
        test_restriction_modes();
        test_random_phases();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("circular_deque verification clean");
        else
            $display("circular_deque verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result beat", {m_tuser, m_tdata[37:0]}, '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 40'(m_tuser), 40'(want.status));
                if (m_tdata[31:0] !== want.removed)
                    report_mismatch("removed value", 40'(m_tdata[31:0]), 40'(want.removed));
                if (m_tdata[36:32] !== want.count)
                    report_mismatch("count", 40'(m_tdata[36:32]), 40'(want.count));
                if (m_tdata[39:37] !== 3'b000)
                    report_mismatch("tdata padding", 40'(m_tdata[39:37]), '0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("circular_deque verification failed");
            $finish;
        end
    end

endmodule
